// ===== hdl/e2q_pkg.sv =====
// ---------------------------------------------------------------------------
// e2q_pkg
// types, constants and the arctangent table for the euler to quaternion block
// ---------------------------------------------------------------------------
package e2q_pkg;

    localparam int ANGLE_W           = 16;
    localparam int QUAT_W            = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_TABLE_SIZE   = 24;
    localparam int CORDIC_W          = 34;
    localparam int CS_W              = 17;
    localparam int PAIR_W            = 2 * CS_W;
    localparam int TRIPLE_W          = PAIR_W + CS_W;
    localparam int QSUM_W            = TRIPLE_W + 1;
    localparam int Q_W               = 31;
    localparam int SQ_W              = 58;
    localparam int RT_W              = SQ_W + 1;
    localparam int SQRT_STEPS        = 29;
    localparam int LEN_W             = SQRT_STEPS;
    localparam int MAG_W             = Q_W;
    localparam int DIV_STEPS         = 16;
    localparam int NUM_W             = MAG_W + 14;

    localparam logic signed [CORDIC_W-1:0] K_Q30       = 34'sd652032874;
    localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CORDIC_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic [DIV_STEPS-1:0]       ONE_Q14     = 16'd16384;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll_angle;
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] yaw_angle;
    } angle_req_t;

    typedef struct packed {
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
    } quat_req_t;

    function automatic logic signed [CORDIC_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [CORDIC_W-1:0] v;
        unique case (idx)
            5'd0:    v = 34'sh03243F6A8;
            5'd1:    v = 34'sh01DAC6705;
            5'd2:    v = 34'sh00FADBAFC;
            5'd3:    v = 34'sh007F56EA6;
            5'd4:    v = 34'sh003FEAB76;
            5'd5:    v = 34'sh001FFD55B;
            5'd6:    v = 34'sh000FFFAAA;
            5'd7:    v = 34'sh0007FFF55;
            5'd8:    v = 34'sh0003FFFEA;
            5'd9:    v = 34'sh0001FFFFD;
            5'd10:   v = 34'sh0000FFFFF;
            5'd11:   v = 34'sh00007FFFF;
            5'd12:   v = 34'sh00003FFFF;
            5'd13:   v = 34'sh00001FFFF;
            5'd14:   v = 34'sh00000FFFF;
            5'd15:   v = 34'sh000007FFF;
            5'd16:   v = 34'sh000003FFF;
            5'd17:   v = 34'sh000001FFF;
            5'd18:   v = 34'sh000000FFF;
            5'd19:   v = 34'sh0000007FF;
            5'd20:   v = 34'sh0000003FF;
            5'd21:   v = 34'sh0000001FF;
            5'd22:   v = 34'sh0000000FF;
            5'd23:   v = 34'sh00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/euler_to_quaternion_top.sv =====
// ---------------------------------------------------------------------------
// euler_to_quaternion_top
// roll, pitch and yaw (Q3.13 radians) to a normalized ZYX quaternion (Q1.14)
// ---------------------------------------------------------------------------
// Fully pipelined: one request of three angles is taken every cycle while the
// output is not stalled. The pipeline is made of the unrolled CORDIC (one stage
// per iteration), the 29-step square root of the sum of squares and the 16-step
// restoring divider that normalizes the four components. A stall on the output
// holds the whole pipeline, and the input is stalled only while a result waits
// on a stalled output.
module euler_to_quaternion_top #(
    parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                angle_valid,
    output logic                angle_stall,
    input  e2q_pkg::angle_req_t angles,
    output logic                quat_valid,
    input  logic                quat_stall,
    output e2q_pkg::quat_req_t  quat
);

    localparam int N   = (CORDIC_STAGES > e2q_pkg::ATAN_TABLE_SIZE) ?
                         e2q_pkg::ATAN_TABLE_SIZE : CORDIC_STAGES;
    localparam int CW  = e2q_pkg::CORDIC_W;
    localparam int SQS = e2q_pkg::SQRT_STEPS;
    localparam int DVS = e2q_pkg::DIV_STEPS;
    localparam int QPD = SQS + 2;
    localparam int LAT = N + SQS + DVS + 9;

    logic adv;
    logic [LAT-1:0] vld_reg;

    assign adv         = !(quat_valid && quat_stall);
    assign angle_stall = !adv;
    assign quat_valid  = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], angle_valid};
        end
    end

    // fold and cordic
    logic signed [e2q_pkg::ANGLE_W-1:0] ang [0:2];
    logic signed [CW-1:0] cx_reg [0:N][0:2];
    logic signed [CW-1:0] cy_reg [0:N][0:2];
    logic signed [CW-1:0] cz_reg [0:N][0:2];
    logic                 cf_reg [0:N][0:2];

    assign ang[0] = angles.roll_angle;
    assign ang[1] = angles.pitch_angle;
    assign ang[2] = angles.yaw_angle;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 3; l++)
            begin
                logic signed [CW-1:0] z;
                z = {{2{ang[l][e2q_pkg::ANGLE_W-1]}}, ang[l], 16'h0000};
                cx_reg[0][l] <= e2q_pkg::K_Q30;
                cy_reg[0][l] <= '0;
                if (z > e2q_pkg::HALF_PI_Q30)
                begin
                    cz_reg[0][l] <= z - e2q_pkg::PI_Q30;
                    cf_reg[0][l] <= 1'b1;
                end
                else if (z < -e2q_pkg::HALF_PI_Q30)
                begin
                    cz_reg[0][l] <= z + e2q_pkg::PI_Q30;
                    cf_reg[0][l] <= 1'b1;
                end
                else
                begin
                    cz_reg[0][l] <= z;
                    cf_reg[0][l] <= 1'b0;
                end
            end
        end
    end

    for (genvar i = 1; i <= N; i++)
    begin : g_cordic
        localparam logic signed [CW-1:0] ATAN = e2q_pkg::atan_q30(5'(i - 1));
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    cf_reg[i][l] <= cf_reg[i-1][l];
                    if (cz_reg[i-1][l] >= 0)
                    begin
                        cx_reg[i][l] <= cx_reg[i-1][l] - (cy_reg[i-1][l] >>> (i - 1));
                        cy_reg[i][l] <= cy_reg[i-1][l] + (cx_reg[i-1][l] >>> (i - 1));
                        cz_reg[i][l] <= cz_reg[i-1][l] - ATAN;
                    end
                    else
                    begin
                        cx_reg[i][l] <= cx_reg[i-1][l] + (cy_reg[i-1][l] >>> (i - 1));
                        cy_reg[i][l] <= cy_reg[i-1][l] - (cx_reg[i-1][l] >>> (i - 1));
                        cz_reg[i][l] <= cz_reg[i-1][l] + ATAN;
                    end
                end
            end
        end
    end

    // round to q.15, pair and triple products
    logic signed [e2q_pkg::CS_W-1:0]     cc_reg [0:2];
    logic signed [e2q_pkg::CS_W-1:0]     cs_reg [0:2];
    logic signed [e2q_pkg::PAIR_W-1:0]   pp_reg [0:3];
    logic signed [e2q_pkg::CS_W-1:0]     ycc_reg;
    logic signed [e2q_pkg::CS_W-1:0]     ycs_reg;
    logic signed [e2q_pkg::TRIPLE_W-1:0] tp_reg [0:7];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 3; l++)
            begin
                logic signed [CW-1:0] xf;
                logic signed [CW-1:0] yf;
                logic signed [CW-1:0] xr;
                logic signed [CW-1:0] yr;
                xf = cf_reg[N][l] ? -cx_reg[N][l] : cx_reg[N][l];
                yf = cf_reg[N][l] ? -cy_reg[N][l] : cy_reg[N][l];
                xr = (xf + 34'sd16384) >>> 15;
                yr = (yf + 34'sd16384) >>> 15;
                cc_reg[l] <= xr[e2q_pkg::CS_W-1:0];
                cs_reg[l] <= yr[e2q_pkg::CS_W-1:0];
            end
            pp_reg[0] <= cc_reg[0] * cc_reg[1];
            pp_reg[1] <= cs_reg[0] * cs_reg[1];
            pp_reg[2] <= cs_reg[0] * cc_reg[1];
            pp_reg[3] <= cc_reg[0] * cs_reg[1];
            ycc_reg   <= cc_reg[2];
            ycs_reg   <= cs_reg[2];
            tp_reg[0] <= pp_reg[0] * ycc_reg;
            tp_reg[1] <= pp_reg[1] * ycs_reg;
            tp_reg[2] <= pp_reg[2] * ycc_reg;
            tp_reg[3] <= pp_reg[3] * ycs_reg;
            tp_reg[4] <= pp_reg[3] * ycc_reg;
            tp_reg[5] <= pp_reg[2] * ycs_reg;
            tp_reg[6] <= pp_reg[0] * ycs_reg;
            tp_reg[7] <= pp_reg[1] * ycc_reg;
        end
    end

    // components, squares and their sum
    logic signed [e2q_pkg::QSUM_W-1:0] qsum [0:3];
    logic signed [e2q_pkg::Q_W-1:0]    qp_reg [0:QPD][0:3];
    logic [e2q_pkg::SQ_W-1:0]          sq_reg [0:3];
    logic [e2q_pkg::RT_W-1:0]          rem_reg [0:SQS];
    logic [e2q_pkg::RT_W-1:0]          res_reg [0:SQS];

    assign qsum[0] = tp_reg[0] + tp_reg[1];
    assign qsum[1] = tp_reg[2] - tp_reg[3];
    assign qsum[2] = tp_reg[4] + tp_reg[5];
    assign qsum[3] = tp_reg[6] - tp_reg[7];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                logic signed [e2q_pkg::QSUM_W-1:0] qr;
                logic signed [2*e2q_pkg::Q_W-1:0]  sq;
                qr = (qsum[k] + 52'sd65536) >>> 17;
                sq = qp_reg[0][k] * qp_reg[0][k];
                qp_reg[0][k] <= qr[e2q_pkg::Q_W-1:0];
                sq_reg[k]    <= sq[e2q_pkg::SQ_W-1:0];
                for (int j = 1; j <= QPD; j++)
                begin
                    qp_reg[j][k] <= qp_reg[j-1][k];
                end
            end
            rem_reg[0] <= e2q_pkg::RT_W'(sq_reg[0]) + e2q_pkg::RT_W'(sq_reg[1])
                        + e2q_pkg::RT_W'(sq_reg[2]) + e2q_pkg::RT_W'(sq_reg[3]);
            res_reg[0] <= '0;
        end
    end

    // square root, one result bit per stage
    for (genvar s = 1; s <= SQS; s++)
    begin : g_sqrt
        localparam logic [e2q_pkg::RT_W-1:0] BIT =
            e2q_pkg::RT_W'(1) << (2 * (SQS - s));
        logic [e2q_pkg::RT_W-1:0] trial;
        assign trial = res_reg[s-1] + BIT;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (rem_reg[s-1] >= trial)
                begin
                    rem_reg[s] <= rem_reg[s-1] - trial;
                    res_reg[s] <= (res_reg[s-1] >> 1) + BIT;
                end
                else
                begin
                    rem_reg[s] <= rem_reg[s-1];
                    res_reg[s] <= res_reg[s-1] >> 1;
                end
            end
        end
    end

    // normalizing divide, one quotient bit per stage
    logic [e2q_pkg::NUM_W-1:0] dr_reg   [0:DVS][0:3];
    logic [DVS-1:0]            dq_reg   [0:DVS][0:3];
    logic                      dsg_reg  [0:DVS][0:3];
    logic [e2q_pkg::LEN_W-1:0] dlen_reg [0:DVS];
    logic                      dz_reg   [0:DVS];
    logic [e2q_pkg::LEN_W-1:0] len;

    assign len = res_reg[SQS][e2q_pkg::LEN_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dlen_reg[0] <= len;
            dz_reg[0]   <= (len == '0);
            for (int k = 0; k < 4; k++)
            begin
                logic signed [e2q_pkg::Q_W-1:0] qv;
                logic [e2q_pkg::MAG_W-1:0]      mag;
                qv  = qp_reg[QPD][k];
                mag = qv[e2q_pkg::Q_W-1] ? e2q_pkg::MAG_W'(-qv) : e2q_pkg::MAG_W'(qv);
                dr_reg[0][k]  <= (e2q_pkg::NUM_W'(mag) << 14)
                               + e2q_pkg::NUM_W'(len >> 1);
                dq_reg[0][k]  <= '0;
                dsg_reg[0][k] <= qv[e2q_pkg::Q_W-1];
            end
        end
    end

    for (genvar j = 1; j <= DVS; j++)
    begin : g_div
        logic [e2q_pkg::NUM_W-1:0] dv;
        assign dv = e2q_pkg::NUM_W'(dlen_reg[j-1]) << (DVS - j);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dlen_reg[j] <= dlen_reg[j-1];
                dz_reg[j]   <= dz_reg[j-1];
                for (int k = 0; k < 4; k++)
                begin
                    dsg_reg[j][k] <= dsg_reg[j-1][k];
                    if (dr_reg[j-1][k] >= dv)
                    begin
                        dr_reg[j][k] <= dr_reg[j-1][k] - dv;
                        dq_reg[j][k] <= {dq_reg[j-1][k][DVS-2:0], 1'b1};
                    end
                    else
                    begin
                        dr_reg[j][k] <= dr_reg[j-1][k];
                        dq_reg[j][k] <= {dq_reg[j-1][k][DVS-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // saturate, restore sign; the identity quaternion for a zero length
    logic [e2q_pkg::QUAT_W-1:0] qo [0:3];
    e2q_pkg::quat_req_t         quat_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            logic [DVS-1:0] sat;
            sat   = (dq_reg[DVS][k] > e2q_pkg::ONE_Q14) ? e2q_pkg::ONE_Q14
                                                        : dq_reg[DVS][k];
            qo[k] = dsg_reg[DVS][k] ? e2q_pkg::QUAT_W'(-sat) : e2q_pkg::QUAT_W'(sat);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (dz_reg[DVS])
            begin
                quat_reg.quat_w <= e2q_pkg::QUAT_W'(e2q_pkg::ONE_Q14);
                quat_reg.quat_x <= '0;
                quat_reg.quat_y <= '0;
                quat_reg.quat_z <= '0;
            end
            else
            begin
                quat_reg.quat_w <= qo[0];
                quat_reg.quat_x <= qo[1];
                quat_reg.quat_y <= qo[2];
                quat_reg.quat_z <= qo[3];
            end
        end
    end

    assign quat = quat_reg;

endmodule

// ===== hdl/e2q_checker.sv =====
// ---------------------------------------------------------------------------
// e2q_checker
// port level checks for the euler to quaternion block
// ---------------------------------------------------------------------------
module e2q_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                angle_valid,
    input logic                angle_stall,
    input e2q_pkg::angle_req_t angles,
    input logic                quat_valid,
    input logic                quat_stall,
    input e2q_pkg::quat_req_t  quat
);

    // held result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && quat_stall |=> quat_valid && $stable(quat))
        else $error("stalled result changed");

    // input blocked only behind a waiting result
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        angle_stall |-> quat_valid && quat_stall)
        else $error("input stalled without a waiting result");

    // unit range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid |-> quat.quat_w <= 16384 && quat.quat_w >= -16384
                    && quat.quat_x <= 16384 && quat.quat_x >= -16384
                    && quat.quat_y <= 16384 && quat.quat_y >= -16384
                    && quat.quat_z <= 16384 && quat.quat_z >= -16384)
        else $error("component out of range");

    // a unit quaternion is never all zero
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid |-> quat.quat_w != 0 || quat.quat_x != 0
                    || quat.quat_y != 0 || quat.quat_z != 0)
        else $error("zero quaternion");

endmodule

bind euler_to_quaternion_top e2q_checker u_e2q_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// euler_to_quaternion_top testbench
// drives angle requests through the pipeline under varied idling and stalls
// and checks each quaternion against a local fixed-point predictor
// ---------------------------------------------------------------------------
module testbench;

    localparam int LATENCY   = e2q_pkg::CORDIC_STAGES_DEF + 54;
    localparam int IDLE_MAX  = 2000;
    localparam int NSTAGES   = e2q_pkg::CORDIC_STAGES_DEF > e2q_pkg::ATAN_TABLE_SIZE ?
                               e2q_pkg::ATAN_TABLE_SIZE : e2q_pkg::CORDIC_STAGES_DEF;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                angle_valid = 1'b0;
    logic                angle_stall;
    e2q_pkg::angle_req_t angles = '0;
    logic                quat_valid;
    logic                quat_stall = 1'b0;
    e2q_pkg::quat_req_t  quat;

    e2q_pkg::quat_req_t  quat_expected[$];
    int         errors = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_cycles = 0;
    int         idle_count = 0;

    longint     atan_tbl[e2q_pkg::ATAN_TABLE_SIZE] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

    euler_to_quaternion_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .angle_valid (angle_valid),
        .angle_stall (angle_stall),
        .angles      (angles),
        .quat_valid  (quat_valid),
        .quat_stall  (quat_stall),
        .quat        (quat)
    );

    always #10 clk = ~clk;

    function automatic void half_angle_trig(input logic signed [15:0] a,
                                            output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z = longint'(a) * 65536;
        x = 64'sd652032874;
        y = 0;
        flip = 0;
        if (z > 64'sd1686629713)
        begin
            z -= 64'sd3373259426;
            flip = 1;
        end
        else if (z < -64'sd1686629713)
        begin
            z += 64'sd3373259426;
            flip = 1;
        end
        for (int i = 0; i < NSTAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atan_tbl[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atan_tbl[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = (x + 16384) >>> 15;
        s = (y + 16384) >>> 15;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] norm_q14(longint c, longint unsigned len);
        longint unsigned mag;
        longint          q;
        mag = c < 0 ? -c : c;
        q = ((mag << 14) + len / 2) / len;
        if (q > 16384)
            q = 16384;
        if (c < 0)
            q = -q;
        return q[15:0];
    endfunction

    function automatic e2q_pkg::quat_req_t predict_quat(e2q_pkg::angle_req_t a);
        longint             cr, sr, cp, sp, cy, sy;
        longint             q[4];
        longint unsigned    sum;
        longint unsigned    len;
        e2q_pkg::quat_req_t r;
        half_angle_trig(a.roll_angle, cr, sr);
        half_angle_trig(a.pitch_angle, cp, sp);
        half_angle_trig(a.yaw_angle, cy, sy);
        q[0] = cr * cp * cy + sr * sp * sy;
        q[1] = sr * cp * cy - cr * sp * sy;
        q[2] = cr * sp * cy + sr * cp * sy;
        q[3] = cr * cp * sy - sr * sp * cy;
        sum = 0;
        for (int k = 0; k < 4; k++)
        begin
            q[k] = (q[k] + 65536) >>> 17;
            sum += longint'(q[k] * q[k]);
        end
        len = int_sqrt(sum);
        if (len == 0)
        begin
            r = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
            return r;
        end
        r.quat_w = norm_q14(q[0], len);
        r.quat_x = norm_q14(q[1], len);
        r.quat_y = norm_q14(q[2], len);
        r.quat_z = norm_q14(q[3], len);
        return r;
    endfunction

    // called at a falling edge; leaves valid high after the accepting edge
    task automatic send_angles(input e2q_pkg::angle_req_t a);
        while ($urandom_range(99) < send_idle_pct)
        begin
            angle_valid <= 1'b0;
            @(negedge clk);
        end
        angles      <= a;
        angle_valid <= 1'b1;
        do
            @(posedge clk);
        while (angle_stall);
        quat_expected.push_back(predict_quat(a));
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_angle();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 16'($urandom);
        return $signed(16'($urandom_range(51472))) - 16'sd25736;
    endfunction

    // receiver stall, with an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            quat_stall  <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            quat_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && quat_valid && !quat_stall)
        begin
            if (quat_expected.size() == 0)
            begin
                $display("%0t: unexpected quaternion %h", $time, quat);
                errors++;
            end
            else
            begin
                if (quat !== quat_expected[0])
                begin
                    $display("%0t: expected w=%0d x=%0d y=%0d z=%0d got w=%0d x=%0d y=%0d z=%0d",
                             $time, quat_expected[0].quat_w, quat_expected[0].quat_x,
                             quat_expected[0].quat_y, quat_expected[0].quat_z,
                             quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z);
                    errors++;
                end
                void'(quat_expected.pop_front());
            end
        end
    end

    // watchdog on cycles without any accepted request or accepted result
    always @(posedge clk)
    begin
        if ((angle_valid && !angle_stall) || (quat_valid && !quat_stall))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count > IDLE_MAX)
        begin
            $display("euler_to_quaternion_top: mismatch");
            $finish;
        end
    end

    task automatic test_directed();
        logic signed [15:0] vals[10] = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868,
            -16'sd12868, 16'sd12869, -16'sd12869, 16'sh7FFF, 16'sh8000, 16'sd1};
        for (int i = 0; i < 10; i++)
            send_angles('{vals[i], vals[(i + 3) % 10], vals[(i + 7) % 10]});
        send_angles('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        send_angles('{16'sh8000, 16'sh8000, 16'sh8000});
        send_angles('{16'sh5555, 16'shAAAA, 16'sh5555});
        send_angles('{16'shAAAA, 16'sh5555, 16'shAAAA});
        send_angles('{-16'sd1, -16'sd1, -16'sd1});
    endtask

    task automatic test_random(input int n, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++)
            send_angles('{rand_angle(), rand_angle(), rand_angle()});
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        angle_valid <= 1'b0;
        @(negedge clk);
        hold_cycles = 300;
        for (int i = 0; i < 150; i++)
            send_angles('{rand_angle(), rand_angle(), rand_angle()});
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(350, 0, 0);
        test_random(350, 54, 0);
        test_random(350, 0, 54);
        test_random(350, 19, 19);
        test_backpressure();
        angle_valid <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (quat_expected.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0)
            $display("euler_to_quaternion_top: match");
        else
            $display("euler_to_quaternion_top: mismatch");
        $finish;
    end

endmodule
